// File: hw/rtl/mct_pkg.sv
`timescale 1ns / 1ps

package mct_pkg;

  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned IdW          = 5;

  typedef enum logic [1:0] {
    KIND_ADD_OK   = 2'd0,
    KIND_ADD_FULL = 2'd1,
    KIND_FIRED    = 2'd2,
    KIND_TICK_END = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MODE_TICK_ONCE = 2'd0,
    MODE_TICK_REP  = 2'd1,
    MODE_MS_ONCE   = 2'd2,
    MODE_MS_REP    = 2'd3
  } mode_e;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ADD  = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] now_ms;
    logic [1:0]  mode;
    logic [31:0] period;
  } in_t;

  typedef struct packed {
    logic [1:0]     kind;
    logic [IdW-1:0] event_id;
    logic [31:0]    elapsed_ms;
    logic [63:0]    tick_total;
    logic           last;
  } out_t;

  // one slot as kept in the slot memory
  typedef struct packed {
    logic [1:0]  mode;
    logic        done;
    logic [31:0] countdown;
    logic [31:0] reload;
  } slot_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic add;
    logic stamp;
    logic walk;
    logic finish;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_last;
  } sts_t;

endpackage

// File: hw/rtl/mct_ctrl.sv
`timescale 1ns / 1ps

module mct_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          cmd_add_i,
  input  mct_pkg::sts_t sts_i,
  output mct_pkg::ctl_t ctl_o,
  output logic          busy_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADD   = 3'd1;
  localparam logic [2:0] ST_STAMP = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          state_d    = (cmd_add_i == mct_pkg::CMD_ADD) ? ST_ADD : ST_STAMP;
        end
      end
      ST_ADD: begin
        ctl_o.add = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_STAMP: begin
        ctl_o.stamp = 1'b1;
        state_d     = ST_WALK;
      end
      ST_WALK: begin
        ctl_o.walk = 1'b1;
        if (sts_i.walk_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        ctl_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// File: hw/rtl/mct_dp.sv
`timescale 1ns / 1ps

module mct_dp #(
  parameter int unsigned SLOTS = mct_pkg::SlotsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mct_pkg::in_t   cmd_i,
  input  logic           cfg_valid_i,
  input  logic           cfg_data_i,
  input  mct_pkg::ctl_t  ctl_i,
  output mct_pkg::sts_t  sts_o,
  output logic           result_valid_o,
  output mct_pkg::out_t  result_o
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned IDF_W = (CNT_W + 1 > mct_pkg::IdW) ? CNT_W + 1 : mct_pkg::IdW;

  mct_pkg::slot_t mem [SLOTS];

  mct_pkg::in_t   in_q;
  logic           en_q;
  logic [CNT_W-1:0] used_q;
  logic [31:0]    prev_q;
  logic [63:0]    cnt_q;
  logic [31:0]    elapsed_q;
  logic [IDX_W-1:0] idx_q;
  logic           proc_v_q;
  logic [IDX_W-1:0] proc_idx_q;
  mct_pkg::slot_t rd_q;
  logic           out_v_q, out_v_d;
  mct_pkg::out_t  out_q, out_d;

  logic           full;
  logic           active;
  logic           is_ms;
  logic           expired;
  logic           fire;
  mct_pkg::slot_t upd;
  logic           wr_en;
  logic [IDX_W-1:0] wr_addr;
  mct_pkg::slot_t wr_data;
  logic [IDF_W-1:0] add_id, fire_id;
  logic [63:0]    cnt_inc;

  assign full   = (used_q == CNT_W'(SLOTS));
  assign sts_o.walk_last = (idx_q == IDX_W'(SLOTS - 1));
  assign cnt_inc = cnt_q + 64'd1;

  // slot update for the entry read last cycle
  always_comb begin
    active  = proc_v_q && (CNT_W'(proc_idx_q) < used_q) && !rd_q.done;
    is_ms   = rd_q.mode[1];
    upd     = rd_q;
    expired = is_ms ? (rd_q.countdown <= elapsed_q) : (rd_q.countdown <= 32'd1);
    if (!expired) begin
      upd.countdown = is_ms ? (rd_q.countdown - elapsed_q) : (rd_q.countdown - 32'd1);
    end else if (rd_q.mode[0]) begin
      upd.countdown = rd_q.reload;
    end else begin
      upd.done = 1'b1;
      if (is_ms) begin
        upd.countdown = 32'd0;
      end
    end
    fire = active && expired;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = proc_idx_q;
    wr_data = upd;
    if (ctl_i.add) begin
      wr_en             = !full;
      wr_addr           = used_q[IDX_W-1:0];
      wr_data.mode      = in_q.mode;
      wr_data.done      = 1'b0;
      wr_data.countdown = in_q.period;
      wr_data.reload    = in_q.period;
    end else if (active) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl_i.walk) begin
      rd_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      in_q <= cmd_i;
    end
    out_q <= out_d;
  end

  assign add_id  = IDF_W'(used_q) + IDF_W'(1);
  assign fire_id = IDF_W'(proc_idx_q) + IDF_W'(1);

  always_comb begin
    out_v_d             = 1'b0;
    out_d.kind          = mct_pkg::KIND_TICK_END;
    out_d.event_id      = '0;
    out_d.elapsed_ms    = elapsed_q;
    out_d.tick_total    = cnt_q;
    out_d.last          = 1'b1;
    if (ctl_i.add) begin
      out_v_d = 1'b1;
      if (full) begin
        out_d.kind = mct_pkg::KIND_ADD_FULL;
      end else begin
        out_d.kind     = mct_pkg::KIND_ADD_OK;
        out_d.event_id = add_id[mct_pkg::IdW-1:0];
      end
    end else if (fire && en_q) begin
      out_v_d        = 1'b1;
      out_d.kind     = mct_pkg::KIND_FIRED;
      out_d.event_id = fire_id[mct_pkg::IdW-1:0];
      out_d.last     = 1'b0;
    end else if (ctl_i.finish) begin
      out_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q       <= 1'b0;
      used_q     <= '0;
      prev_q     <= '0;
      cnt_q      <= '0;
      elapsed_q  <= '0;
      idx_q      <= '0;
      proc_v_q   <= 1'b0;
      proc_idx_q <= '0;
      out_v_q    <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      proc_v_q <= ctl_i.walk;
      if (cfg_valid_i) begin
        en_q <= cfg_data_i;
      end
      if (ctl_i.add && !full) begin
        used_q <= used_q + CNT_W'(1);
      end
      if (ctl_i.stamp) begin
        cnt_q     <= cnt_inc;
        prev_q    <= in_q.now_ms;
        elapsed_q <= (cnt_q == 64'd0) ? 32'd0 : (in_q.now_ms - prev_q);
        idx_q     <= '0;
      end
      if (ctl_i.walk) begin
        proc_idx_q <= idx_q;
        if (!sts_o.walk_last) begin
          idx_q <= idx_q + IDX_W'(1);
        end
      end
    end
  end

  assign result_valid_o = out_v_q;
  assign result_o       = out_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(SLOTS))
    else $error("slot count beyond table size");

  a_add_walk_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.add && (ctl_i.walk || proc_v_q)))
    else $error("add overlaps slot walk");

  a_proc_follows_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_v_q |-> $past(ctl_i.walk))
    else $error("slot processed without a read");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.last) |=> !out_v_q)
    else $error("beat directly after final beat");

endmodule

// File: hw/rtl/multi_slot_countdown_event_timer.sv
`timescale 1ns / 1ps

// Bank of SLOTS countdown timers, one-shot or recurring, in ticks or ms.
// Command channel: cmd_i is taken at a clock edge with start high and busy low.
//   An add claims the next slot; a tick carries a millisecond timestamp.
// Result channel: result_o is valid for one cycle while result_valid_o is
//   high; the receiver cannot stall it. result_o.last marks the final beat
//   of a command.
// Config channel: cfg_data_i sets the report enable when cfg_valid_i is high;
//   cfg_ready_o is always high. Write it only while the block is idle.
// Add: one beat, registered from the add state; the next command is taken at
//   the edge that takes that beat.
// Tick: a timestamp step, then one slot per cycle through a slot memory
//   with one read and one write port, a drain step for the read pipe and a
//   completion step. Fired-event beats come out in slot order.
// Reset empties the table and clears the tick counter, time base and enable;
// no clearing pass is needed and a command is taken at the first edge after
// reset.
module multi_slot_countdown_event_timer #(
  parameter int unsigned SLOTS = mct_pkg::SlotsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  mct_pkg::in_t  cmd_i,
  output logic          result_valid_o,
  output mct_pkg::out_t result_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_data_i
);

  mct_pkg::ctl_t ctl;
  mct_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  mct_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .cmd_add_i (cmd_i.cmd),
    .sts_i     (sts),
    .ctl_o     (ctl),
    .busy_o    (busy)
  );

  mct_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// File: test/multi_slot_countdown_event_timer_test.sv
`timescale 1ns / 1ps

module multi_slot_countdown_event_timer_test;

  localparam int unsigned SLOTS        = mct_pkg::SlotsDefault;
  localparam int unsigned QuietLimit   = 1000;
  localparam int unsigned SettleCycles = SLOTS + 8;

  class timer_scoreboard;
    bit              armed[SLOTS];
    mct_pkg::mode_e  style[SLOTS];
    logic [31:0]     remaining[SLOTS];
    logic [31:0]     reload[SLOTS];
    int unsigned     claimed;
    logic [31:0]     prev_stamp;
    logic [31:0]     gap_ms;
    logic [63:0]     ticks;
    bit              report_en;
    mct_pkg::out_t   due_q[$];
    int unsigned     fails;

    function new();
      foreach (armed[i]) armed[i] = 1'b0;
      claimed    = 0;
      prev_stamp = '0;
      gap_ms     = '0;
      ticks      = '0;
      report_en  = 1'b0;
      fails      = 0;
    endfunction

    function mct_pkg::out_t beat_of(logic [1:0] kind, int unsigned id, logic last);
      mct_pkg::out_t r;
      r.kind       = kind;
      r.event_id   = mct_pkg::IdW'(id);
      r.elapsed_ms = gap_ms;
      r.tick_total = ticks;
      r.last       = last;
      return r;
    endfunction

    function void expect_beat(mct_pkg::out_t b);
      due_q.insert(due_q.size(), b);
    endfunction

    function void note_cmd(mct_pkg::in_t c);
      bit fire;
      if (c.cmd == mct_pkg::CMD_ADD) begin
        if (claimed >= SLOTS) begin
          expect_beat(beat_of(mct_pkg::KIND_ADD_FULL, 0, 1'b1));
        end else begin
          armed[claimed]     = 1'b1;
          style[claimed]     = mct_pkg::mode_e'(c.mode);
          remaining[claimed] = c.period;
          reload[claimed]    = c.period;
          claimed++;
          expect_beat(beat_of(mct_pkg::KIND_ADD_OK, claimed, 1'b1));
        end
        return;
      end
      ticks = ticks + 64'd1;
      // first tick defines the time base
      if (ticks == 64'd1) prev_stamp = c.now_ms;
      gap_ms     = c.now_ms - prev_stamp;
      prev_stamp = c.now_ms;
      for (int i = 0; i < SLOTS; i++) begin
        fire = 1'b0;
        if (armed[i]) begin
          if (style[i] == mct_pkg::MODE_TICK_ONCE || style[i] == mct_pkg::MODE_TICK_REP) begin
            if (remaining[i] > 32'd1) remaining[i] = remaining[i] - 32'd1;
            else fire = 1'b1;
          end else if (remaining[i] > gap_ms) begin
            remaining[i] = remaining[i] - gap_ms;
          end else begin
            fire = 1'b1;
          end
          if (fire) begin
            if (style[i] == mct_pkg::MODE_TICK_ONCE ||
                style[i] == mct_pkg::MODE_MS_ONCE) begin
              armed[i] = 1'b0;
            end
            remaining[i] = reload[i];
            if (report_en) expect_beat(beat_of(mct_pkg::KIND_FIRED, i + 1, 1'b0));
          end
        end
      end
      expect_beat(beat_of(mct_pkg::KIND_TICK_END, 0, 1'b1));
    endfunction

    function void check_beat(mct_pkg::out_t got);
      mct_pkg::out_t want;
      if (due_q.size() == 0) begin
        $error("result with nothing expected: kind %0d event_id %0d",
               got.kind, got.event_id);
        fails++;
        return;
      end
      want = due_q.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        fails++;
      end
      if (got.event_id !== want.event_id) begin
        $error("event_id: expected %0d, got %0d", want.event_id, got.event_id);
        fails++;
      end
      if (got.elapsed_ms !== want.elapsed_ms) begin
        $error("elapsed_ms: expected %0h, got %0h", want.elapsed_ms, got.elapsed_ms);
        fails++;
      end
      if (got.tick_total !== want.tick_total) begin
        $error("tick_total: expected %0d, got %0d", want.tick_total, got.tick_total);
        fails++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        fails++;
      end
    endfunction
  endclass

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            start       = 1'b0;
  logic            busy;
  mct_pkg::in_t    cmd_i       = '0;
  logic            result_valid_o;
  mct_pkg::out_t   result_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic            cfg_data_i  = 1'b0;
  timer_scoreboard sb;
  logic [31:0]     stamp       = '0;
  int unsigned     quiet       = 0;

  multi_slot_countdown_event_timer #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_cmd(cmd_i);
      if (result_valid_o) sb.check_beat(result_o);
      if (cfg_valid_i && cfg_ready_o) sb.report_en = cfg_data_i;
      if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
        quiet <= 0;
      end else if (quiet >= QuietLimit) begin
        $display("multi_slot_countdown_event_timer test failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  function automatic mct_pkg::in_t tick_at(logic [31:0] now);
    mct_pkg::in_t it;
    it.cmd    = mct_pkg::CMD_TICK;
    it.now_ms = now;
    it.mode   = 2'($urandom_range(3));
    it.period = $urandom();
    return it;
  endfunction

  function automatic mct_pkg::in_t add_of(mct_pkg::mode_e m, logic [31:0] p);
    mct_pkg::in_t it;
    it.cmd    = mct_pkg::CMD_ADD;
    it.now_ms = $urandom();
    it.mode   = m;
    it.period = p;
    return it;
  endfunction

  task automatic send(mct_pkg::in_t item, int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    cmd_i <= item;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_reporting(logic en);
    settle();
    cfg_data_i  <= en;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(int unsigned count, int unsigned idle_pct);
    mct_pkg::in_t   it;
    mct_pkg::mode_e m;
    logic [31:0]    p;
    for (int unsigned n = 0; n < count; n++) begin
      if (n == count / 2) settle();
      if ($urandom_range(99) < 9) begin
        m = mct_pkg::mode_e'($urandom_range(3));
        if ($urandom_range(4) == 0) p = $urandom();
        else if (m == mct_pkg::MODE_TICK_ONCE || m == mct_pkg::MODE_TICK_REP) begin
          p = $urandom_range(6);
        end
        else p = $urandom_range(300);
        it = add_of(m, p);
      end else begin
        case ($urandom_range(11))
          0:       stamp = $urandom();
          1:       stamp = stamp - 32'($urandom_range(3));
          default: stamp = stamp + 32'($urandom_range(60));
        endcase
        it = tick_at(stamp);
      end
      send(it, idle_pct);
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reporting off at reset: state still advances
    send(tick_at(32'hFFFF_FFF0), 0);
    send(add_of(mct_pkg::MODE_TICK_ONCE, 32'd0), 0);
    send(add_of(mct_pkg::MODE_TICK_REP, 32'd1), 0);
    send(add_of(mct_pkg::MODE_MS_ONCE, 32'd0), 0);
    send(add_of(mct_pkg::MODE_MS_REP, 32'd0), 0);
    send(add_of(mct_pkg::MODE_MS_REP, 32'hFFFF_FFFF), 0);
    send(add_of(mct_pkg::MODE_TICK_ONCE, 32'd3), 0);
    send(add_of(mct_pkg::MODE_TICK_REP, 32'd2), 0);
    send(add_of(mct_pkg::MODE_MS_ONCE, 32'd100), 0);
    send(tick_at(32'hFFFF_FFF8), 0);
    set_reporting(1'b1);
    send(tick_at(32'h0000_0010), 0);
    send(tick_at(32'h0000_0010), 0);
    send(tick_at(32'h0000_0090), 0);
    send(tick_at(32'hFFFF_FFFF), 0);
    send(tick_at(32'h0000_0000), 0);
    send(tick_at(32'h0000_0005), 0);
    stamp = 32'h0000_0005;

    set_reporting(1'b0);
    run_random(100, 14);
    set_reporting(1'b1);
    run_random(100, 48);
    run_random(100, 0);

    settle();
    if (sb.fails == 0 && sb.due_q.size() == 0) begin
      $display("multi_slot_countdown_event_timer test passed");
    end else begin
      $display("multi_slot_countdown_event_timer test failed");
    end
    $finish;
  end

endmodule
